// ----- src/qft_pkg.sv -----
// shared types and character constants for the quoted field tokenizer
package qft_pkg;

  localparam int LEN_W = 11;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_EOD  = 1'b1;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [3:0] {
    M_START  = 4'b0001,
    M_FIELD  = 4'b0010,
    M_CRPEND = 4'b0100,
    M_SKIP   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] field_length;
    logic             was_quoted;
    logic             last_of_step;
  } out_t;

  typedef struct packed {
    mode_t            mode;
    logic             in_quotes;
    logic [LEN_W-1:0] count;
  } state_t;

  // results of one input beat: zero, one or two tokens
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } step_t;

endpackage

// ----- src/qft_step.sv -----
// per-character parse logic: next state and the tokens one beat causes
module qft_step import qft_pkg::*; #(
  parameter int MAX_FIELD_LEN = 1024
) (
  input  state_t cur,
  input  in_t    beat,
  output state_t nxt,
  output step_t  res
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_FIELD_LEN);

  logic [7:0]       c;
  logic             ws;
  logic [LEN_W-1:0] cnt_inc;
  logic             full;
  logic             act_end;
  logic             act_store;
  out_t             end_cur;
  out_t             end_inc;
  out_t             byte_tok;

  assign c       = beat.in_byte;
  assign ws      = (c == CH_SPACE) || (c == CH_TAB);
  assign cnt_inc = cur.count + LEN_W'(1);
  assign full    = cnt_inc >= MaxLen;

  always_comb begin
    end_cur = '{kind: KIND_END, data_byte: 8'h00, field_length: cur.count,
                was_quoted: cur.in_quotes, last_of_step: 1'b0};
    end_inc = '{kind: KIND_END, data_byte: 8'h00, field_length: cnt_inc,
                was_quoted: cur.in_quotes, last_of_step: 1'b0};
    byte_tok = '{kind: KIND_BYTE, data_byte: (beat.func == FUNC_EOD) ? CH_CR : c,
                 field_length: '0, was_quoted: 1'b0, last_of_step: 1'b0};
  end

  always_comb begin
    nxt       = cur;
    res       = '0;
    act_end   = 1'b0;
    act_store = 1'b0;

    if (beat.func == FUNC_EOD) begin
      // end of buffer flushes an open field, a pending cr becomes data
      unique case (cur.mode)
        M_FIELD: begin
          res.n  = 2'd1;
          res.r0 = end_cur;
        end
        M_CRPEND: begin
          res.n  = 2'd2;
          res.r0 = byte_tok;
          res.r1 = end_inc;
        end
        default: ;
      endcase
      nxt = '{mode: M_START, in_quotes: 1'b0, count: '0};
    end else begin
      unique case (cur.mode)
        M_CRPEND: begin
          if (c == CH_LF) begin
            act_end  = 1'b1;
            nxt.mode = M_START;
          end else begin
            act_store = 1'b1;
          end
        end
        M_SKIP: begin
          if ((c == CH_COMMA) || (c == CH_LF)) nxt.mode = M_START;
        end
        default: begin
          // start drops leading whitespace, then both act as in-field
          if ((cur.mode != M_FIELD) && ws) begin
            nxt.mode = M_START;
          end else begin
            nxt.mode = M_FIELD;
            priority if (c == CH_LF) begin
              act_end  = 1'b1;
              nxt.mode = M_START;
            end else if (c == CH_CR) begin
              nxt.mode = M_CRPEND;
            end else if ((c == CH_QUOTE) && cur.in_quotes) begin
              act_end  = 1'b1;
              nxt.mode = M_SKIP;
            end else if ((c == CH_QUOTE) && (cur.count == '0)) begin
              nxt.in_quotes = 1'b1;
            end else if ((c == CH_COMMA) && !cur.in_quotes) begin
              act_end  = 1'b1;
              nxt.mode = M_START;
            end else if (ws && !cur.in_quotes) begin
              nxt.mode = M_FIELD;
            end else begin
              act_store = 1'b1;
            end
          end
        end
      endcase

      if (act_end) begin
        res.n         = 2'd1;
        res.r0        = end_cur;
        nxt.count     = '0;
        nxt.in_quotes = 1'b0;
      end
      if (act_store) begin
        res.n  = 2'd1;
        res.r0 = byte_tok;
        if (full) begin
          res.n         = 2'd2;
          res.r1        = end_inc;
          nxt.mode      = M_SKIP;
          nxt.count     = '0;
          nxt.in_quotes = 1'b0;
        end else begin
          nxt.mode  = M_FIELD;
          nxt.count = cnt_inc;
        end
      end
    end

    // flag the final token of this beat
    if (res.n == 2'd1) res.r0.last_of_step = 1'b1;
    if (res.n == 2'd2) res.r1.last_of_step = 1'b1;
  end

endmodule

// ----- src/qft_outq.sv -----
// four-entry token queue taking up to two tokens per cycle
module qft_outq import qft_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t res,
  output logic  room,
  output logic  tok_valid,
  input  logic  tok_stall,
  output out_t  tok_beat
);

  out_t       store_q [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] fill;
  logic [1:0] n_in;
  logic       pop;

  assign n_in      = push ? res.n : 2'd0;
  assign pop       = tok_valid && !tok_stall;
  assign tok_valid = fill != 3'd0;
  assign tok_beat  = store_q[head];
  assign room      = fill <= 3'd2;

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) store_q[tail] <= res.r0;
    if (n_in == 2'd2) store_q[tail + 2'd1] <= res.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + n_in;
      if (pop) head <= head + 2'd1;
      fill <= fill + {1'b0, n_in} - {2'b00, pop};
    end
  end

endmodule

// ----- src/quoted_field_tokenizer.sv -----
// top level of the quoted field tokenizer
//
//  channel | direction | payload | meaning
//  char    | in        | in_t    | one character or end-of-buffer mark
//  tok     | out       | out_t   | one field byte or one end-of-field token
//
// one character beat is taken per cycle unless stalled; the parse state
// update is a single pass of logic from the state registers into the
// token queue; a beat yields zero, one or two tokens; the token port
// drains one per cycle unless stalled, so beats that yield two tokens set
// the sustained rate on that side; char_stall rises while the queue lacks
// room for two tokens; rst clears the parse state and empties the queue
module quoted_field_tokenizer import qft_pkg::*; #(
  parameter int MAX_FIELD_LEN = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic char_valid,
  output logic char_stall,
  input  in_t  char_beat,
  output logic tok_valid,
  input  logic tok_stall,
  output out_t tok_beat
);

  state_t state;
  state_t state_next;
  step_t  res;
  logic   room;
  logic   take;

  // a beat is taken only when the queue can hold both possible tokens
  assign char_stall = !room;
  assign take       = char_valid && room;

  qft_step #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN)
  ) u_step (
    .cur  (state),
    .beat (char_beat),
    .nxt  (state_next),
    .res  (res)
  );

  qft_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .res       (res),
    .room      (room),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_beat  (tok_beat)
  );

  // parse state: mode, quote flag and byte count of the open field
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: M_START, in_quotes: 1'b0, count: '0};
    end else if (take) begin
      state <= state_next;
    end
  end

endmodule
